[design/bthin_pkg.sv]
package bthin_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_SIZE   = 3;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int ITEM_W    = 1 + COL_W + ROW_W;

    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    localparam int THIN_MIN_SAME = 3;
    localparam int THIN_MAX_SAME = 7;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        SEL_LAST_UP,
        SEL_THIN,
        SEL_CENTRE,
        SEL_UPPER,
        SEL_MIDDLE
    } val_sel_t;

    typedef struct packed {
        logic             valid;
        logic             wr;
        logic             px;
        logic [COL_W-1:0] addr;
        logic             col_last;
        logic             emit;
        val_sel_t         sel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } stage_req_t;

    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             pix;
    } out_item_t;

    // index of the last row/column after clamping the size to [MIN_SIZE, max]
    function automatic logic [COL_W-1:0] size_last(logic [CFG_W-1:0] v, logic [CFG_W-1:0] max);
        logic [CFG_W-1:0] last;
        if (v < CFG_W'(MIN_SIZE)) begin
            last = CFG_W'(MIN_SIZE - 1);
        end else if (v > max) begin
            last = max - CFG_W'(1);
        end else begin
            last = v - CFG_W'(1);
        end
        return last[COL_W-1:0];
    endfunction

    // window: bits 6..8 col c-2, 3..5 col c-1, 0..2 col c (top, middle, bottom)
    function automatic logic thin_centre(logic [8:0] w);
        logic       c;
        logic [7:0] ring;
        logic [7:0] nxt;
        logic [3:0] steps;
        logic [3:0] same;
        c     = w[4];
        ring  = {w[7], w[8], w[5], w[2], w[1], w[0], w[3], w[6]};
        nxt   = {ring[0], ring[7:1]};
        steps = '0;
        same  = '0;
        for (int k = 0; k < 8; k++) begin
            steps = steps + {3'b0, ring[k] & ~nxt[k]};
            same  = same + {3'b0, ring[k] == c};
        end
        if (steps == 4'd1 && same >= 4'(THIN_MIN_SAME) && same <= 4'(THIN_MAX_SAME) &&
            (ring[1] != c || ring[3] != c || (ring[7] != c && ring[5] != c))) begin
            return 1'b0;
        end
        return c;
    endfunction

endpackage

[design/bthin_ctrl.sv]
module bthin_ctrl
    import bthin_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_accept,
    input  logic                 in_px,
    input  logic                 in_flush,
    output logic [COL_W-1:0]     rd_addr,
    output stage_req_t           req_reg
);

    localparam logic [COL_W-1:0] WLAST_RESET =
        size_last(CFG_W'(RESET_WIDTH), CFG_W'(MAX_WIDTH));
    localparam logic [ROW_W-1:0] HLAST_RESET =
        ROW_W'(size_last(CFG_W'(RESET_HEIGHT), CFG_W'(MAX_HEIGHT)));

    logic [COL_W-1:0] wlast_reg, wlast_next;
    logic [ROW_W-1:0] hlast_reg, hlast_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic             complete_reg, complete_next;
    logic [COL_W-1:0] em_col_reg, em_col_next;
    logic [ROW_W-1:0] em_row_reg, em_row_next;
    stage_req_t       req_next;
    logic             take_px;
    logic             take_fl;

    assign take_px = in_accept && !in_flush && !complete_reg;
    assign take_fl = in_accept && in_flush && complete_reg;
    assign rd_addr = complete_reg ? em_col_reg : in_col_reg;

    always_comb begin
        wlast_next    = wlast_reg;
        hlast_next    = hlast_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        complete_next = complete_reg;
        em_col_next   = em_col_reg;
        em_row_next   = em_row_reg;

        req_next          = '0;
        req_next.sel      = SEL_CENTRE;
        req_next.px       = in_px;
        req_next.addr     = rd_addr;
        req_next.col      = em_col_reg;
        req_next.row      = em_row_reg;
        req_next.last     = (em_col_reg == wlast_reg) && (em_row_reg == hlast_reg);
        req_next.col_last = in_col_reg == wlast_reg;

        if (take_px) begin
            req_next.valid = 1'b1;
            req_next.wr    = 1'b1;
            req_next.emit  = !(in_row_reg == '0 || (in_row_reg == ROW_W'(1) && in_col_reg == '0));
            if (in_col_reg == '0) begin
                req_next.sel = SEL_LAST_UP;
            end else if (in_row_reg >= ROW_W'(2) && in_col_reg >= COL_W'(2)) begin
                req_next.sel = SEL_THIN;
            end else begin
                req_next.sel = SEL_CENTRE;
            end
            if (in_col_reg == wlast_reg) begin
                in_col_next = '0;
                if (in_row_reg == hlast_reg) begin
                    in_row_next   = '0;
                    complete_next = 1'b1;
                end else begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end else if (take_fl) begin
            req_next.valid = 1'b1;
            req_next.emit  = 1'b1;
            req_next.sel   = (em_row_reg == hlast_reg) ? SEL_MIDDLE : SEL_UPPER;
        end

        if (req_next.emit) begin
            if (req_next.last) begin
                in_col_next   = '0;
                in_row_next   = '0;
                complete_next = 1'b0;
                em_col_next   = '0;
                em_row_next   = '0;
            end else if (em_col_reg == wlast_reg) begin
                em_col_next = '0;
                em_row_next = em_row_reg + ROW_W'(1);
            end else begin
                em_col_next = em_col_reg + COL_W'(1);
            end
        end

        if (cfg_we) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH: begin
                    wlast_next = size_last(cfg_data, CFG_W'(MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT: begin
                    hlast_next = ROW_W'(size_last(cfg_data, CFG_W'(MAX_HEIGHT)));
                end
                default: begin
                    wlast_next = wlast_reg;
                end
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            complete_next = 1'b0;
            em_col_next   = '0;
            em_row_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg    <= WLAST_RESET;
            hlast_reg    <= HLAST_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            complete_reg <= 1'b0;
            em_col_reg   <= '0;
            em_row_reg   <= '0;
            req_reg      <= '0;
        end else begin
            wlast_reg    <= wlast_next;
            hlast_reg    <= hlast_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            complete_reg <= complete_next;
            em_col_reg   <= em_col_next;
            em_row_reg   <= em_row_next;
            req_reg      <= req_next;
        end
    end

    a_complete_col: assert property (@(posedge aclk) disable iff (!aresetn)
        complete_reg |-> (in_col_reg == '0))
        else $error("input column not cleared once frame input is complete");

    a_pos_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_col_reg <= wlast_reg) && (in_row_reg <= hlast_reg) &&
        (em_col_reg <= wlast_reg) && (em_row_reg <= hlast_reg))
        else $error("position counter out of frame");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_reg.valid && req_reg.emit && req_reg.last) |->
        (!complete_reg && in_col_reg == '0 && in_row_reg == '0 &&
         em_col_reg == '0 && em_row_reg == '0))
        else $error("counters not restarted after frame end");

endmodule

[design/bthin_lines.sv]
module bthin_lines
    import bthin_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [COL_W-1:0] rd_addr,
    input  stage_req_t       req,
    output logic             res_valid,
    output out_item_t        res
);

    // each entry: {upper row, middle row}
    logic [1:0] line_mem [MAX_WIDTH];
    logic [1:0] rd_reg;
    logic [8:0] window_reg, window_next;
    logic       last_up_reg;
    logic       wr_en;
    logic [1:0] wr_data;

    assign wr_en       = req.valid && req.wr;
    assign wr_data     = {rd_reg[0], req.px};
    assign window_next = {window_reg[5:0], req.px, rd_reg[0], rd_reg[1]};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[req.addr] <= wr_data;
        end
    end

    // forward a same-edge write to the read
    always_ff @(posedge aclk) begin
        if (wr_en && req.addr == rd_addr) begin
            rd_reg <= wr_data;
        end else begin
            rd_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (wr_en) begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && req.col_last) begin
            last_up_reg <= rd_reg[0];
        end
    end

    assign res_valid = req.valid && req.emit;

    always_comb begin
        res.last = req.last;
        res.row  = req.row;
        res.col  = req.col;
        unique case (req.sel)
            SEL_LAST_UP: res.pix = last_up_reg;
            SEL_THIN:    res.pix = thin_centre(window_next);
            SEL_CENTRE:  res.pix = window_next[4];
            SEL_UPPER:   res.pix = rd_reg[1];
            SEL_MIDDLE:  res.pix = rd_reg[0];
            default:     res.pix = window_next[4];
        endcase
    end

endmodule

[design/bthin_obuf.sv]
module bthin_obuf
    import bthin_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_item,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    out_item_t              buf_mem [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OBUF_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CNT_W-1:0]  count_reg, count_next;
    logic                   pop;

    // room for the request in flight plus one more
    assign in_ready = (count_reg + OBUF_CNT_W'(push)) < OBUF_CNT_W'(OBUF_DEPTH);
    assign m_valid  = count_reg != '0;
    assign m_item   = buf_mem[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + OBUF_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OBUF_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OBUF_CNT_W'(push) - OBUF_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && count_reg == OBUF_CNT_W'(OBUF_DEPTH)))
        else $error("output buffer overflow");

endmodule

[design/binary_thinning_pass.sv]
// One parallel thinning pass over a 1-bit raster image, one request per clock
// on both sides while neither stalls. Each pixel's result leaves after
// image_width+1 further input positions; after the last pixel of a frame send
// image_width+1 flush requests (s_tuser = 1) to drain it. The two line stores
// share one memory that is read on acceptance and written back the following
// cycle, with same-address forwarding, so a new request can enter every cycle
// while the output buffer has room. A four-entry output buffer absorbs m_tready
// stalls. Line memory needs no clearing after reset; every entry is written
// within a frame before it is used.
module binary_thinning_pass
    import bthin_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] pixel_in
    input  logic                 s_tuser,   // flush
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] pixel_out, [10:1] out_col, [20:11] out_row
    output logic                 m_tlast,   // frame_end
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data
);

    stage_req_t       req;
    logic [COL_W-1:0] rd_addr;
    logic             in_accept;
    logic             res_valid;
    out_item_t        res;
    out_item_t        m_item;

    assign in_accept = s_tvalid && s_tready;

    bthin_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_px     (s_tdata[0]),
        .in_flush  (s_tuser),
        .rd_addr   (rd_addr),
        .req_reg   (req)
    );

    bthin_lines u_lines (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_addr   (rd_addr),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    bthin_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_item (res),
        .in_ready  (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (m_item)
    );

    assign m_tdata = {(M_TDATA_W - ITEM_W)'(0), m_item.row, m_item.col, m_item.pix};
    assign m_tlast = m_item.last;

endmodule

[tb/sv/tb_binary_thinning_pass.sv]
module tb_binary_thinning_pass;
    import bthin_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } px_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [0] pixel_in
    logic                 s_tuser  = 1'b0;  // flush
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [0] pixel_out, [10:1] out_col, [20:11] out_row
    logic                 m_tlast;          // frame_end
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    binary_thinning_pass dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow of the block's registers and line state
    logic [CFG_W-1:0] img_w_reg = CFG_W'(RESET_WIDTH);
    logic [CFG_W-1:0] img_h_reg = CFG_W'(RESET_HEIGHT);
    bit               line_up  [MAX_WIDTH];
    bit               line_mid [MAX_WIDTH];
    logic [8:0]       win      = '0;
    int unsigned      in_col   = 0;
    int unsigned      in_row   = 0;
    int unsigned      out_cnt  = 0;

    px_result_t expected_px[$];
    int         err_count      = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         hold_left      = 0;

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned maxv);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic thin_decision(input logic [8:0] wv);
        logic ctr;
        logic nb [8];
        int   falls;
        int   agree;
        ctr = wv[4];
        // NW N NE E SE S SW W
        nb = '{wv[6], wv[3], wv[0], wv[1], wv[2], wv[5], wv[8], wv[7]};
        falls = 0;
        agree = 0;
        for (int k = 0; k < 8; k++) begin
            if (nb[k] && !nb[(k + 1) % 8]) falls++;
            if (nb[k] == ctr) agree++;
        end
        if (falls == 1 && agree >= 3 && agree <= 7 &&
            (nb[1] != ctr || nb[3] != ctr || (nb[7] != ctr && nb[5] != ctr)))
            return 1'b0;
        return ctr;
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_cnt = 0;
    endfunction

    function automatic bit thin_step(input logic px, input logic fl, output px_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned e;
        logic        top;
        logic        mid;
        logic        last_up;
        logic        val;
        w   = clamp_size(img_w_reg, MAX_WIDTH);
        h   = clamp_size(img_h_reg, MAX_HEIGHT);
        res = '{pix: 1'b0, col: '0, row: '0, last: 1'b0};
        if (!fl) begin
            if (in_row >= h) return 1'b0;
            c       = (in_col >= w) ? w - 1 : in_col;
            r       = in_row;
            top     = line_up[c];
            mid     = line_mid[c];
            last_up = line_up[w-1];
            line_up[c]  = mid;
            line_mid[c] = px;
            win = {win[5:0], px, mid, top};
            if (c + 1 >= w) begin
                in_col = 0;
                in_row = r + 1;
            end else begin
                in_col = c + 1;
            end
            if (r == 0 || (r == 1 && c == 0)) return 1'b0;
            if (c == 0) begin
                val = last_up;
            end else if (r >= 2 && c >= 2) begin
                val = thin_decision(win);
            end else begin
                val = win[4];
            end
        end else begin
            if (in_row < h) return 1'b0;
            c   = out_cnt % w;
            r   = out_cnt / w;
            val = (r + 1 >= h) ? line_mid[c] : line_up[c];
        end
        e        = out_cnt;
        res.pix  = val;
        res.col  = COL_W'(e % w);
        res.row  = ROW_W'(e / w);
        out_cnt  = e + 1;
        res.last = (out_cnt >= w * h);
        if (res.last) restart_frame();
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= 50) $display("ERROR %0t: %s", $time, msg);
    endtask

    always @(posedge aclk) begin : result_check
        px_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_px.size() == 0) begin
                flag_mismatch($sformatf("unexpected result data=%h last=%b", m_tdata, m_tlast));
            end else begin
                want = expected_px.pop_front();
                if (m_tdata[0] !== want.pix)
                    flag_mismatch($sformatf("pixel_out %b, want %b at r%0d c%0d",
                                            m_tdata[0], want.pix, want.row, want.col));
                if (m_tdata[10:1] !== want.col)
                    flag_mismatch($sformatf("out_col %0d, want %0d", m_tdata[10:1], want.col));
                if (m_tdata[20:11] !== want.row)
                    flag_mismatch($sformatf("out_row %0d, want %0d", m_tdata[20:11], want.row));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("frame_end %b, want %b at r%0d c%0d",
                                            m_tlast, want.last, want.row, want.col));
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic use_idling(input int src, input int snk);
        src_idle_pct   = src;
        sink_stall_pct = snk;
    endtask

    task automatic send_req(input logic px, input logic fl);
        px_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, px};
        s_tuser  <= fl;
        do @(posedge aclk); while (!s_tready);
        if (thin_step(px, fl, res)) expected_px.push_back(res);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) img_w_reg = val;
        else img_h_reg = val;
        restart_frame();
    endtask

    // blob: a filled rectangle with density as its flip rate; cut > 0 stops mid-frame
    task automatic send_frame(input int density, input bit blob, input int noise_pct,
                              input int cut);
        int unsigned w;
        int unsigned h;
        int unsigned r0;
        int unsigned r1;
        int unsigned c0;
        int unsigned c1;
        int          sent;
        logic        px;
        w    = clamp_size(img_w_reg, MAX_WIDTH);
        h    = clamp_size(img_h_reg, MAX_HEIGHT);
        r0   = $urandom_range(h - 2);
        r1   = $urandom_range(h - 1, r0 + 1);
        c0   = $urandom_range(w - 2);
        c1   = $urandom_range(w - 1, c0 + 1);
        sent = 0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (cut > 0 && sent >= cut) return;
                if ($urandom_range(99) < noise_pct) send_req(1'($urandom_range(1)), 1'b1);
                if (blob)
                    px = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^
                         ($urandom_range(99) < density);
                else
                    px = ($urandom_range(99) < density);
                send_req(px, 1'b0);
                sent++;
            end
        end
        for (int k = 0; k <= w; k++) begin
            if ($urandom_range(99) < noise_pct) send_req(1'($urandom_range(1)), 1'b0);
            send_req(1'($urandom_range(1)), 1'b1);
        end
    endtask

    // partial frame at the reset size, then abandoned by the next register write
    task automatic test_reset_size();
        use_idling(0, 0);
        send_frame(50, 1'b0, 0, 24);
        wait_idle();
    endtask

    task automatic test_directed();
        logic [8:0] step_pat  = 9'b000_111_111;
        logic [8:0] cross_pat = 9'b010_111_010;
        use_idling(0, 0);
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
        send_req(1'b1, 1'b1);
        for (int i = 8; i >= 0; i--) send_req(step_pat[i], 1'b0);
        send_req(1'b1, 1'b0);
        repeat (4) send_req(1'b0, 1'b1);
        for (int i = 8; i >= 0; i--) send_req(cross_pat[i], 1'b0);
        repeat (4) send_req(1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        use_idling(0, 0);
        write_reg(REG_IMAGE_WIDTH, CFG_W'(8));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(5));
        hold_left = 200;
        send_frame(10, 1'b1, 0, 0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int          phase_items;
        int          cut;
        bit          stale;
        int          src_pct [4] = '{0, 87, 0, 32};
        int          snk_pct [4] = '{0, 0, 87, 32};
        stale = 1'b1;
        for (int p = 0; p < 4; p++) begin
            use_idling(src_pct[p], snk_pct[p]);
            phase_items = 0;
            while (phase_items < 160) begin
                if (stale || $urandom_range(1)) begin
                    wait_idle();
                    case ($urandom_range(9))
                        0: w = $urandom_range(2);
                        1: w = $urandom_range(40, 13);
                        default: w = $urandom_range(12, 3);
                    endcase
                    h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
                    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
                    stale = 1'b0;
                end
                w   = clamp_size(img_w_reg, MAX_WIDTH);
                h   = clamp_size(img_h_reg, MAX_HEIGHT);
                cut = ($urandom_range(9) == 0) ? $urandom_range(w * h - 1, 1) : 0;
                if ($urandom_range(1))
                    send_frame($urandom_range(15), 1'b1, $urandom_range(1) * 5, cut);
                else
                    send_frame($urandom_range(90, 10), 1'b0, $urandom_range(1) * 5, cut);
                if (cut > 0) begin
                    phase_items += cut;
                    stale = 1'b1;
                end else begin
                    phase_items += w * h + w + 1;
                end
            end
        end
        wait_idle();
    endtask

    // sizes above the maximum whose low 10 bits would give a tiny size
    task automatic test_size_limits();
        use_idling(0, 0);
        write_reg(REG_IMAGE_WIDTH, CFG_W'(1025));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
        send_frame(50, 1'b0, 0, 30);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(1027));
        send_frame(50, 1'b0, 0, 24);
        wait_idle();
    endtask

    initial begin
        int guard;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_size();
        test_directed();
        test_backpressure();
        test_random_frames();
        test_size_limits();
        guard = 0;
        while (expected_px.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (16) @(posedge aclk);
        if (expected_px.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_px.size()));
        if (err_count == 0) begin
            $display("PASS binary_thinning_pass");
        end else begin
            $display("FAIL binary_thinning_pass");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL binary_thinning_pass");
        $finish;
    end

endmodule

[filelist.f]
design/bthin_pkg.sv
design/bthin_ctrl.sv
design/bthin_lines.sv
design/bthin_obuf.sv
design/binary_thinning_pass.sv
tb/sv/tb_binary_thinning_pass.sv
